FILE: rtl/gspls_pkg.sv
`timescale 1ns / 1ps

package gspls_pkg;

    localparam int SENSOR_COUNT_DEF = 8;

    localparam int POS_W   = 13;
    localparam int ERR_W   = 14;
    localparam int OERR_W  = 13;
    localparam int GAIN_W  = 24;
    localparam int SPEED_W = 8;
    localparam int SUM_W   = 15;
    localparam int FRAC_BITS = 24;
    localparam int Q_W     = 41;
    localparam int S_W     = Q_W - FRAC_BITS;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam int ZONE_STRAIGHT = 500;
    localparam int ZONE_CURVE    = 1500;
    localparam int SUM_LIMIT     = 10000;
    localparam int REVERSE_BOOST = 28;
    localparam int DUTY_MAX      = 255;

    localparam logic [GAIN_W-1:0]  RST_GAIN_STRAIGHT  = 24'd31877;
    localparam logic [GAIN_W-1:0]  RST_GAIN_CURVE     = 24'd318767;
    localparam logic [GAIN_W-1:0]  RST_GAIN_SHARP     = 24'd402653;
    localparam logic [GAIN_W-1:0]  RST_GAIN_INTEGRAL  = 24'd201;
    localparam logic [SPEED_W-1:0] RST_SPEED_STRAIGHT = 8'd85;
    localparam logic [SPEED_W-1:0] RST_SPEED_CURVE    = 8'd75;
    localparam logic [SPEED_W-1:0] RST_SPEED_SHARP    = 8'd65;
    localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT    = 8'd95;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_STRAIGHT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CURVE     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHARP     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_STRAIGHT = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CURVE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SHARP    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 4'd7;

    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_REV  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [SPEED_W-1:0] duty;
    } t_wheel;

endpackage

FILE: rtl/gain_scheduled_pi_line_steer_unit.sv
// Gain-scheduled PI line steering for a two-wheel drive.
//
// Input channel: i_valid / o_stall with i_line_position. An item is taken at
// a clock edge with i_valid high and o_stall low. Output channel: o_valid /
// i_stall with wheel modes, duties and the signed line error.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
// selects one of eight registers, i_cfg_data carries the value (8-bit
// registers keep the low byte). Write only while no item is in flight.
//
// Pipeline: input register, error/zone/integral, two products, wheel sums,
// truncate/clamp/split into the output register. One item per cycle is
// sustained while the receiver does not stall; the integral accumulate is
// a single add and clamp, so consecutive items never wait.
// When the receiver stalls, the stages fill up behind the held output and
// o_stall rises only once every stage holds an item.
// Reset clears all valids, the error integral and loads the default gains
// and speeds.
`timescale 1ns / 1ps

module gain_scheduled_pi_line_steer_unit #(
    parameter int SENSOR_COUNT = gspls_pkg::SENSOR_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [gspls_pkg::POS_W-1:0]        i_line_position,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_left_mode,
    output logic [gspls_pkg::SPEED_W-1:0]      o_left_duty,
    output logic [1:0]                         o_right_mode,
    output logic [gspls_pkg::SPEED_W-1:0]      o_right_duty,
    output logic signed [gspls_pkg::OERR_W-1:0] o_line_error,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gspls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gspls_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gspls_pkg::*;

    localparam int Center = (SENSOR_COUNT - 1) * 500;
    localparam int PosMax = (SENSOR_COUNT - 1) * 1000;

    function automatic t_wheel f_wheel(input logic signed [Q_W-1:0] q,
                                       input logic [SPEED_W-1:0] lim);
        logic signed [S_W-1:0] s;
        logic signed [S_W-1:0] l;
        logic [9:0]            m;
        t_wheel                w;
        s = q[Q_W-1:FRAC_BITS];
        if (q[Q_W-1] && (|q[FRAC_BITS-1:0])) begin
            s = s + S_W'(1);
        end
        l = signed'(S_W'({1'b0, lim}));
        if (s > l) begin
            s = l;
        end
        if (s < -l) begin
            s = -l;
        end
        m = 10'(-s) + 10'(REVERSE_BOOST);
        if (s > 0) begin
            w.mode = MODE_FWD;
            w.duty = s[SPEED_W-1:0];
        end else if (s < 0) begin
            w.mode = MODE_REV;
            w.duty = (m > 10'(DUTY_MAX)) ? SPEED_W'(DUTY_MAX) : m[SPEED_W-1:0];
        end else begin
            w.mode = MODE_STOP;
            w.duty = '0;
        end
        return w;
    endfunction

    logic [GAIN_W-1:0]  r_gain_straight, r_gain_curve, r_gain_sharp, r_gain_integral;
    logic [SPEED_W-1:0] r_speed_straight, r_speed_curve, r_speed_sharp, r_speed_limit;
    logic signed [SUM_W-1:0] r_error_sum;

    logic                    r_s1_valid;
    logic [POS_W-1:0]        r_s1_pos;
    logic                    r_s2_valid;
    logic signed [ERR_W-1:0] r_s2_err;
    logic [GAIN_W-1:0]       r_s2_kp;
    logic [SPEED_W-1:0]      r_s2_base;
    logic signed [SUM_W-1:0] r_s2_sum;
    logic                    r_s3_valid;
    logic signed [Q_W-1:0]   r_s3_prod_p, r_s3_prod_i;
    logic [SPEED_W-1:0]      r_s3_base;
    logic signed [ERR_W-1:0] r_s3_err;
    logic                    r_s4_valid;
    logic signed [Q_W-1:0]   r_s4_q_left, r_s4_q_right;
    logic signed [ERR_W-1:0] r_s4_err;
    logic                    r_out_valid;
    t_wheel                  r_left, r_right;
    logic signed [OERR_W-1:0] r_out_err;

    logic w_out_rdy, w_rdy4, w_rdy3, w_rdy2, w_rdy1;

    logic [POS_W-1:0]        w_pos_sat;
    logic signed [ERR_W-1:0] w_err, w_mag;
    logic [GAIN_W-1:0]       w_kp;
    logic [SPEED_W-1:0]      w_base;
    logic signed [SUM_W:0]   w_sum_raw;
    logic signed [SUM_W-1:0] n_error_sum;
    logic signed [Q_W-1:0]   w_base_q;

    assign w_out_rdy = !r_out_valid || !i_stall;
    assign w_rdy4    = !r_s4_valid || w_out_rdy;
    assign w_rdy3    = !r_s3_valid || w_rdy4;
    assign w_rdy2    = !r_s2_valid || w_rdy3;
    assign w_rdy1    = !r_s1_valid || w_rdy2;
    assign o_stall   = !w_rdy1;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_straight  <= RST_GAIN_STRAIGHT;
            r_gain_curve     <= RST_GAIN_CURVE;
            r_gain_sharp     <= RST_GAIN_SHARP;
            r_gain_integral  <= RST_GAIN_INTEGRAL;
            r_speed_straight <= RST_SPEED_STRAIGHT;
            r_speed_curve    <= RST_SPEED_CURVE;
            r_speed_sharp    <= RST_SPEED_SHARP;
            r_speed_limit    <= RST_SPEED_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GAIN_STRAIGHT:  r_gain_straight  <= i_cfg_data;
                REG_GAIN_CURVE:     r_gain_curve     <= i_cfg_data;
                REG_GAIN_SHARP:     r_gain_sharp     <= i_cfg_data;
                REG_GAIN_INTEGRAL:  r_gain_integral  <= i_cfg_data;
                REG_SPEED_STRAIGHT: r_speed_straight <= i_cfg_data[SPEED_W-1:0];
                REG_SPEED_CURVE:    r_speed_curve    <= i_cfg_data[SPEED_W-1:0];
                REG_SPEED_SHARP:    r_speed_sharp    <= i_cfg_data[SPEED_W-1:0];
                REG_SPEED_LIMIT:    r_speed_limit    <= i_cfg_data[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // error, zone and integral
    always_comb begin
        w_pos_sat = (32'(r_s1_pos) > PosMax) ? POS_W'(PosMax) : r_s1_pos;
        w_err = signed'(ERR_W'({1'b0, w_pos_sat})) - ERR_W'(Center);
        w_mag = (w_err < 0) ? -w_err : w_err;
        if (w_mag < ERR_W'(ZONE_STRAIGHT)) begin
            w_kp   = r_gain_straight;
            w_base = r_speed_straight;
        end else if (w_mag < ERR_W'(ZONE_CURVE)) begin
            w_kp   = r_gain_curve;
            w_base = r_speed_curve;
        end else begin
            w_kp   = r_gain_sharp;
            w_base = r_speed_sharp;
        end
        w_sum_raw = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(w_err);
        if (w_sum_raw > (SUM_W+1)'(SUM_LIMIT)) begin
            n_error_sum = SUM_W'(SUM_LIMIT);
        end else if (w_sum_raw < -(SUM_W+1)'(SUM_LIMIT)) begin
            n_error_sum = -SUM_W'(SUM_LIMIT);
        end else begin
            n_error_sum = w_sum_raw[SUM_W-1:0];
        end
    end

    assign w_base_q = signed'(Q_W'({1'b0, r_s3_base, {FRAC_BITS{1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_valid <= i_valid;
            end
            if (w_rdy2) begin
                r_s2_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_error_sum <= n_error_sum;
                end
            end
            if (w_rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_rdy4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (w_out_rdy) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1_pos <= i_line_position;
        end
        if (w_rdy2 && r_s1_valid) begin
            r_s2_err  <= w_err;
            r_s2_kp   <= w_kp;
            r_s2_base <= w_base;
            r_s2_sum  <= n_error_sum;
        end
        if (w_rdy3 && r_s2_valid) begin
            r_s3_prod_p <= Q_W'(signed'({1'b0, r_s2_kp})) * Q_W'(r_s2_err);
            r_s3_prod_i <= Q_W'(signed'({1'b0, r_gain_integral})) * Q_W'(r_s2_sum);
            r_s3_base   <= r_s2_base;
            r_s3_err    <= r_s2_err;
        end
        if (w_rdy4 && r_s3_valid) begin
            r_s4_q_left  <= w_base_q - r_s3_prod_p - r_s3_prod_i;
            r_s4_q_right <= w_base_q + r_s3_prod_p + r_s3_prod_i;
            r_s4_err     <= r_s3_err;
        end
        if (w_out_rdy && r_s4_valid) begin
            r_left    <= f_wheel(r_s4_q_left, r_speed_limit);
            r_right   <= f_wheel(r_s4_q_right, r_speed_limit);
            r_out_err <= r_s4_err[OERR_W-1:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_left_mode  = r_left.mode;
    assign o_left_duty  = r_left.duty;
    assign o_right_mode = r_right.mode;
    assign o_right_duty = r_right.duty;
    assign o_line_error = r_out_err;

endmodule
